FILE: src/cesd_pkg.sv
// cesd_pkg: shared types, character constants and decode helpers for the
// C escape sequence decoder. No dependencies.
`default_nettype none

package cesd_pkg;

    localparam int unsigned CMD_QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LC_A      = 8'h61;
    localparam logic [7:0] CH_LC_F      = 8'h66;
    localparam logic [7:0] CH_UC_A      = 8'h41;
    localparam logic [7:0] CH_UC_F      = 8'h46;
    localparam logic [7:0] CH_LC_X      = 8'h78;
    localparam logic [7:0] HEX_TEN      = 8'd10;

    localparam logic [1:0] OCT_DIGITS_MAX = 2'd3;
    localparam logic [1:0] HEX_DIGITS_MAX = 2'd2;

    typedef enum logic [3:0] {
        PH_NORMAL = 4'b0001,
        PH_ESC    = 4'b0010,
        PH_OCT    = 4'b0100,
        PH_HEX    = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_final;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
    } out_item_t;

    // One accepted item's results: one or two bytes.
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       two;
        logic       fin;
    } cmd_t;

    // {valid, value}
    function automatic logic [8:0] simple_escape(input logic [7:0] b);
        logic [8:0] r;
        begin
            unique case (b)
                8'h61:        r = {1'b1, 8'd7};
                8'h62:        r = {1'b1, 8'd8};
                8'h65:        r = {1'b1, 8'd27};
                8'h66:        r = {1'b1, 8'd12};
                8'h6E:        r = {1'b1, 8'd10};
                8'h72:        r = {1'b1, 8'd13};
                8'h74:        r = {1'b1, 8'd9};
                8'h76:        r = {1'b1, 8'd11};
                CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
                CH_QUOTE:     r = {1'b1, CH_QUOTE};
                CH_DQUOTE:    r = {1'b1, CH_DQUOTE};
                default:      r = 9'd0;
            endcase
            return r;
        end
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [7:0] d;
        logic [4:0] r;
        begin
            d = 8'd0;
            r = 5'd0;
            if (b >= CH_ZERO && b <= CH_NINE) begin
                d = b - CH_ZERO;
                r = {1'b1, d[3:0]};
            end else if (b >= CH_LC_A && b <= CH_LC_F) begin
                d = b - CH_LC_A + HEX_TEN;
                r = {1'b1, d[3:0]};
            end else if (b >= CH_UC_A && b <= CH_UC_F) begin
                d = b - CH_UC_A + HEX_TEN;
                r = {1'b1, d[3:0]};
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/cesd_front.sv
// cesd_front: escape state machine. Takes one character a cycle while take is high and
// turns it into a command of one or two result bytes. Uses cesd_pkg.
`default_nettype none

module cesd_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               take,
    input  wire cesd_pkg::in_item_t item,
    output logic                    cmd_push,
    output cesd_pkg::cmd_t          cmd
);

    cesd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       accum_reg, accum_next;
    logic [1:0]       cnt_reg, cnt_next;

    logic       va, vb, vc;
    logic [7:0] a_val, c_val;
    logic       plain;
    logic [7:0] b;
    logic [8:0] esc;
    logic [4:0] hx;
    logic [1:0] n;

    always_comb
    begin
        b          = item.in_byte;
        esc        = cesd_pkg::simple_escape(b);
        hx         = cesd_pkg::hex_digit(b);
        phase_next = phase_reg;
        accum_next = accum_reg;
        cnt_next   = cnt_reg;
        va         = 1'b0;
        a_val      = accum_reg;
        plain      = 1'b0;
        vb         = 1'b0;
        vc         = 1'b0;
        c_val      = accum_reg;

        unique case (phase_reg)
            cesd_pkg::PH_ESC:
            begin
                if (esc[8]) begin
                    va         = 1'b1;
                    a_val      = esc[7:0];
                    phase_next = cesd_pkg::PH_NORMAL;
                end else if (b >= cesd_pkg::CH_ZERO && b <= cesd_pkg::CH_SEVEN) begin
                    accum_next = {5'd0, b[2:0]};
                    cnt_next   = 2'd1;
                    phase_next = cesd_pkg::PH_OCT;
                end else if (b == cesd_pkg::CH_LC_X) begin
                    accum_next = 8'd0;
                    cnt_next   = 2'd0;
                    phase_next = cesd_pkg::PH_HEX;
                end else begin
                    // unknown escape: backslash, then the byte as is
                    va         = 1'b1;
                    a_val      = cesd_pkg::CH_BACKSLASH;
                    phase_next = cesd_pkg::PH_NORMAL;
                    plain      = 1'b1;
                end
            end
            cesd_pkg::PH_OCT:
            begin
                if (b >= cesd_pkg::CH_ZERO && b <= cesd_pkg::CH_SEVEN
                    && cnt_reg < cesd_pkg::OCT_DIGITS_MAX) begin
                    accum_next = {accum_reg[4:0], b[2:0]};
                    cnt_next   = cnt_reg + 2'd1;
                    if (cnt_next >= cesd_pkg::OCT_DIGITS_MAX) begin
                        va         = 1'b1;
                        a_val      = accum_next;
                        phase_next = cesd_pkg::PH_NORMAL;
                    end
                end else begin
                    va         = 1'b1;
                    a_val      = accum_reg;
                    phase_next = cesd_pkg::PH_NORMAL;
                    plain      = 1'b1;
                end
            end
            cesd_pkg::PH_HEX:
            begin
                if (hx[4] && cnt_reg < cesd_pkg::HEX_DIGITS_MAX) begin
                    accum_next = {accum_reg[3:0], hx[3:0]};
                    cnt_next   = cnt_reg + 2'd1;
                    if (cnt_next >= cesd_pkg::HEX_DIGITS_MAX) begin
                        va         = 1'b1;
                        a_val      = accum_next;
                        phase_next = cesd_pkg::PH_NORMAL;
                    end
                end else begin
                    va         = 1'b1;
                    a_val      = accum_reg;
                    phase_next = cesd_pkg::PH_NORMAL;
                    plain      = 1'b1;
                end
            end
            default:
            begin
                plain = 1'b1;
            end
        endcase

        if (plain) begin
            if (b == cesd_pkg::CH_BACKSLASH)
                phase_next = cesd_pkg::PH_ESC;
            else
                vb = 1'b1;
        end

        // end of string flushes anything pending, then back to reset state
        if (item.in_final) begin
            if (phase_next == cesd_pkg::PH_ESC) begin
                vc    = 1'b1;
                c_val = cesd_pkg::CH_BACKSLASH;
            end else if (phase_next == cesd_pkg::PH_OCT || phase_next == cesd_pkg::PH_HEX) begin
                vc    = 1'b1;
                c_val = accum_next;
            end
            phase_next = cesd_pkg::PH_NORMAL;
            accum_next = 8'd0;
            cnt_next   = 2'd0;
        end

        n = {1'b0, va} + {1'b0, vb} + {1'b0, vc};

        cmd.byte0 = va ? a_val : (vb ? b : c_val);
        cmd.byte1 = (va && vb) ? b : c_val;
        cmd.two   = n[1];
        cmd.fin   = item.in_final;
        cmd_push  = take && (n != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= cesd_pkg::PH_NORMAL;
            accum_reg <= 8'd0;
            cnt_reg   <= 2'd0;
        end else if (take) begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/cesd_queue.sv
// cesd_queue: small command queue between the decode front and the result
// back end. Uses cesd_pkg.
`default_nettype none

module cesd_queue #(
    parameter int unsigned DEPTH = cesd_pkg::CMD_QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire cesd_pkg::cmd_t   wr_cmd,
    input  wire logic             rd,
    output cesd_pkg::cmd_t        head,
    output logic                  full,
    output logic                  empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    cesd_pkg::cmd_t slots_reg [DEPTH];
    logic [PW-1:0]  wp_reg, rp_reg;
    logic [CW-1:0]  cnt_reg;
    logic           do_wr, do_rd;

    assign full  = (cnt_reg == DEPTH_CNT);
    assign empty = (cnt_reg == '0);
    assign head  = slots_reg[rp_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slots_reg[wp_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_wr)
                wp_reg <= (wp_reg == LAST_PTR) ? '0 : wp_reg + PW'(1);
            if (do_rd)
                rp_reg <= (rp_reg == LAST_PTR) ? '0 : rp_reg + PW'(1);
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + CW'(1);
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

endmodule

`default_nettype wire

FILE: src/cesd_back.sv
// cesd_back: walks each queued command one byte at a time into the output
// register and marks run_last / string_end. Uses cesd_pkg.
`default_nettype none

module cesd_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire cesd_pkg::cmd_t head,
    input  wire logic           head_empty,
    output logic                head_pop,
    input  wire logic           pop,
    output logic                empty,
    output cesd_pkg::out_item_t result
);

    cesd_pkg::out_item_t out_reg, out_next;
    logic                vld_reg;
    logic                sub_reg;   // 1: first byte of a two-byte command already sent
    logic                load;
    logic                last_of_cmd;

    assign empty       = !vld_reg;
    assign result      = out_reg;
    assign load        = !head_empty && (!vld_reg || pop);
    assign last_of_cmd = sub_reg || !head.two;
    assign head_pop    = load && last_of_cmd;

    always_comb
    begin
        out_next.out_byte   = sub_reg ? head.byte1 : head.byte0;
        out_next.run_last   = last_of_cmd;
        out_next.string_end = last_of_cmd && head.fin;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
            sub_reg <= 1'b0;
        end else begin
            if (load)
                vld_reg <= 1'b1;
            else if (pop)
                vld_reg <= 1'b0;
            if (load)
                sub_reg <= !last_of_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: src/c_escape_sequence_decoder_core.sv
// c_escape_sequence_decoder_core: top level. Instantiates cesd_front,
// cesd_queue and cesd_back; uses cesd_pkg.
`default_nettype none

// Decodes C escape sequences in a byte stream. One character is taken per
// clock while the command queue has room. Each character yields zero, one
// or two result bytes. Results leave at one per clock while pop is held,
// from a registered output. A two-byte item occupies the output for both
// of its bytes, so a run of such items fills the queue and stalls the
// input. With the queue empty, the first result of an accepted character
// goes through a queue slot and then the output register before it is on
// the result ports. The front holds the escape state (phase, digit value,
// digit count). The queue of QUEUE_DEPTH commands lets it run ahead while
// the output is stalled. A final flag on the last character flushes a
// pending backslash or digit run and resets the escape state.
module c_escape_sequence_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = cesd_pkg::CMD_QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire cesd_pkg::in_item_t char_item,
    output logic                    empty,
    input  wire logic               pop,
    output cesd_pkg::out_item_t     result
);

    logic           take;
    logic           q_wr, q_rd, q_full, q_empty;
    cesd_pkg::cmd_t q_in, q_head;

    assign full = q_full;
    assign take = push && !q_full;

    cesd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .item     (char_item),
        .cmd_push (q_wr),
        .cmd      (q_in)
    );

    cesd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .wr_cmd (q_in),
        .rd     (q_rd),
        .head   (q_head),
        .full   (q_full),
        .empty  (q_empty)
    );

    cesd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_empty (q_empty),
        .head_pop   (q_rd),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr |-> !q_full)
        else $error("command written into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |-> !q_empty)
        else $error("command read from an empty queue");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.string_end) |-> result.run_last)
        else $error("string end flagged on a result that is not last of its item");

endmodule

`default_nettype wire
